// ===== hdl/imm_pkg.sv =====
`default_nettype none

package imm_pkg;

	localparam int MAX_DIM_DEF    = 8;
	localparam int DATA_WIDTH_DEF = 16;
	localparam int ACC_WIDTH      = 40;

	// input actions
	localparam logic [1:0] ACT_WRITE_A  = 2'd0;
	localparam logic [1:0] ACT_WRITE_B  = 2'd1;
	localparam logic [1:0] ACT_MULTIPLY = 2'd2;

	// result status
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_EMPTY    = 2'd1;
	localparam logic [1:0] ST_MISMATCH = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_A_ROWS = 2'd0;
	localparam logic [1:0] REG_A_COLS = 2'd1;
	localparam logic [1:0] REG_B_ROWS = 2'd2;
	localparam logic [1:0] REG_B_COLS = 2'd3;

	typedef struct packed {
		logic [1:0]         action;
		logic [2:0]         row_index;
		logic [2:0]         col_index;
		logic signed [15:0] element_value;
	} in_item_t;

	typedef struct packed {
		logic [1:0]                  status;
		logic [2:0]                  out_row;
		logic [2:0]                  out_col;
		logic signed [ACC_WIDTH-1:0] product_value;
		logic                        last;
	} out_item_t;

	// tag that follows each product term down the pipe
	typedef struct packed {
		logic       valid;
		logic       first;   // first term of a sum
		logic       lastn;   // last term of a sum: emit a result
		logic       last;    // final result of the multiply
		logic [1:0] status;
		logic [2:0] row;
		logic [2:0] col;
	} imm_tag_t;

endpackage

`default_nettype wire

// ===== hdl/imm_ram.sv =====
`default_nettype none

module imm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                           clk,
	input  wire logic                           we,
	input  wire logic [AW-1:0]                  waddr,
	input  wire logic [WIDTH-1:0]               wdata,
	input  wire logic                           re,
	input  wire logic [AW-1:0]                  raddr,
	output logic      [WIDTH-1:0]               rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== hdl/imm_seq.sv =====
`default_nettype none

module imm_seq #(
	parameter int MAX_DIM    = imm_pkg::MAX_DIM_DEF,
	parameter int DATA_WIDTH = imm_pkg::DATA_WIDTH_DEF,
	localparam int AW        = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [3:0]        cfg_data,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire imm_pkg::in_item_t in_data,
	input  wire logic              adv,
	output logic                   a_we,
	output logic                   b_we,
	output logic [AW-1:0]          waddr,
	output logic [DATA_WIDTH-1:0]  wdata,
	output logic [AW-1:0]          a_raddr,
	output logic [AW-1:0]          b_raddr,
	output imm_pkg::imm_tag_t      tag_s1
);

	localparam int CW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

	logic [3:0] a_rows_q, a_cols_q, b_rows_q, b_cols_q;
	logic [3:0] ar, ac, br, bc;
	logic       busy_q;
	logic [1:0] err_q;
	logic [CW-1:0] i_q, j_q, n_q;
	logic       in_acc, wr_ok, acc_mul;
	logic       last_i, last_j, last_n;
	logic [1:0] status_c;
	imm_pkg::imm_tag_t issue_tag;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_rows_q <= 4'd1;
			a_cols_q <= 4'd1;
			b_rows_q <= 4'd1;
			b_cols_q <= 4'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				imm_pkg::REG_A_ROWS: a_rows_q <= cfg_data;
				imm_pkg::REG_A_COLS: a_cols_q <= cfg_data;
				imm_pkg::REG_B_ROWS: b_rows_q <= cfg_data;
				imm_pkg::REG_B_COLS: b_cols_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// saturate dims at MAX_DIM
	assign ar = (int'(a_rows_q) > MAX_DIM) ? 4'(MAX_DIM) : a_rows_q;
	assign ac = (int'(a_cols_q) > MAX_DIM) ? 4'(MAX_DIM) : a_cols_q;
	assign br = (int'(b_rows_q) > MAX_DIM) ? 4'(MAX_DIM) : b_rows_q;
	assign bc = (int'(b_cols_q) > MAX_DIM) ? 4'(MAX_DIM) : b_cols_q;

	assign in_stall = busy_q;
	assign in_acc   = in_valid && !busy_q;
	assign wr_ok    = (int'(in_data.row_index) < MAX_DIM) &&
	                  (int'(in_data.col_index) < MAX_DIM);
	assign acc_mul  = in_acc && (in_data.action == imm_pkg::ACT_MULTIPLY);

	assign a_we  = in_acc && wr_ok && (in_data.action == imm_pkg::ACT_WRITE_A);
	assign b_we  = in_acc && wr_ok && (in_data.action == imm_pkg::ACT_WRITE_B);
	assign waddr = AW'(int'(in_data.row_index) * MAX_DIM + int'(in_data.col_index));
	assign wdata = DATA_WIDTH'(in_data.element_value);

	always_comb begin
		if (ar == 4'd0 || ac == 4'd0 || br == 4'd0 || bc == 4'd0) begin
			status_c = imm_pkg::ST_EMPTY;
		end else if (ac != br) begin
			status_c = imm_pkg::ST_MISMATCH;
		end else begin
			status_c = imm_pkg::ST_OK;
		end
	end

	assign last_i = (5'(i_q) + 5'd1) == {1'b0, ar};
	assign last_j = (5'(j_q) + 5'd1) == {1'b0, bc};
	assign last_n = (5'(n_q) + 5'd1) == {1'b0, ac};

	assign a_raddr = AW'(int'(i_q) * MAX_DIM + int'(n_q));
	assign b_raddr = AW'(int'(n_q) * MAX_DIM + int'(j_q));

	always_comb begin
		issue_tag.valid = busy_q;
		if (err_q != imm_pkg::ST_OK) begin
			issue_tag.first  = 1'b1;
			issue_tag.lastn  = 1'b1;
			issue_tag.last   = 1'b1;
			issue_tag.status = err_q;
			issue_tag.row    = 3'd0;
			issue_tag.col    = 3'd0;
		end else begin
			issue_tag.first  = (n_q == '0);
			issue_tag.lastn  = last_n;
			issue_tag.last   = last_i && last_j;
			issue_tag.status = imm_pkg::ST_OK;
			issue_tag.row    = 3'(i_q);
			issue_tag.col    = 3'(j_q);
		end
	end

	// i, j, n loop counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			err_q  <= imm_pkg::ST_OK;
			i_q    <= '0;
			j_q    <= '0;
			n_q    <= '0;
		end else if (acc_mul) begin
			busy_q <= 1'b1;
			err_q  <= status_c;
			i_q    <= '0;
			j_q    <= '0;
			n_q    <= '0;
		end else if (busy_q && adv) begin
			if (err_q != imm_pkg::ST_OK) begin
				busy_q <= 1'b0;
			end else if (!last_n) begin
				n_q <= n_q + 1'b1;
			end else begin
				n_q <= '0;
				if (!last_j) begin
					j_q <= j_q + 1'b1;
				end else begin
					j_q <= '0;
					if (!last_i) begin
						i_q <= i_q + 1'b1;
					end else begin
						busy_q <= 1'b0;
					end
				end
			end
		end
	end

	// tag lines up with registered RAM data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else if (adv) begin
			tag_s1 <= issue_tag;
		end
	end

`ifndef SYNTHESIS
	a_mul_starts: assert property (@(posedge clk) disable iff (!arst_n)
		acc_mul |=> busy_q)
		else $error("multiply transfer did not start sequencer");
	a_hold_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !adv |=> $stable({i_q, j_q, n_q}))
		else $error("loop counters moved during stall");
	a_err_token: assert property (@(posedge clk) disable iff (!arst_n)
		tag_s1.valid && tag_s1.status != imm_pkg::ST_OK |-> tag_s1.last && tag_s1.lastn)
		else $error("error token not marked last");
`endif

endmodule

`default_nettype wire

// ===== hdl/imm_mac.sv =====
`default_nettype none

module imm_mac #(
	parameter int DATA_WIDTH = imm_pkg::DATA_WIDTH_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire imm_pkg::imm_tag_t      tag_s1,
	input  wire logic [DATA_WIDTH-1:0]  a_rdata,
	input  wire logic [DATA_WIDTH-1:0]  b_rdata,
	output logic                        adv,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output imm_pkg::out_item_t          out_data
);

	localparam int AccW = imm_pkg::ACC_WIDTH;

	imm_pkg::imm_tag_t         tag_s2;
	logic signed [2*DATA_WIDTH-1:0] prod_s2;
	logic signed [AccW-1:0]    acc_q;
	logic signed [AccW-1:0]    sum;
	logic                      out_valid_q;
	imm_pkg::out_item_t        out_q;

	assign adv       = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
		end else if (adv) begin
			tag_s2 <= tag_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s2 <= $signed(a_rdata) * $signed(b_rdata);
		end
	end

	// wraps modulo 2^40
	assign sum = (tag_s2.first ? '0 : acc_q) + AccW'(prod_s2);

	always_ff @(posedge clk) begin
		if (adv && tag_s2.valid) begin
			acc_q <= sum;
		end
		if (adv) begin
			out_q.status        <= tag_s2.status;
			out_q.out_row       <= tag_s2.row;
			out_q.out_col       <= tag_s2.col;
			out_q.product_value <= (tag_s2.status == imm_pkg::ST_OK) ? sum : '0;
			out_q.last          <= tag_s2.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= tag_s2.valid && tag_s2.lastn;
		end
	end

`ifndef SYNTHESIS
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.status != imm_pkg::ST_OK |-> out_q.product_value == '0 && out_q.last)
		else $error("error result carries data or lacks last");
	a_pipe_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(tag_s2))
		else $error("product stage moved during stall");
`endif

endmodule

`default_nettype wire

// ===== hdl/integer_matrix_multiply_core.sv =====
`default_nettype none

// Channel  Signals                          Transfer when
// -------  -------------------------------  --------------------------
// in       in_valid, in_stall, in_data      in_valid && !in_stall
// out      out_valid, out_stall, out_data   out_valid && !out_stall
// cfg      cfg_we, cfg_index, cfg_data      cfg_we
//
// Element writes (A or B) are taken back to back while no multiply runs. A
// multiply of an R x K by K x C matrix holds in_stall high while the i/j/n
// sequencer issues R*C*K read pairs, one per cycle while adv is high; an error
// multiply issues one error token. Results pass the RAM read, product and
// output registers; out_stall on a held result freezes all, sequencer too.
// Reset clears control and sets all dimensions to 1; the stores keep no reset.

module integer_matrix_multiply_core #(
	parameter int MAX_DIM    = imm_pkg::MAX_DIM_DEF,
	parameter int DATA_WIDTH = imm_pkg::DATA_WIDTH_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [1:0]          cfg_index,
	input  wire logic [3:0]          cfg_data,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire imm_pkg::in_item_t   in_data,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output imm_pkg::out_item_t       out_data
);

	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// store write side (from input) and read side (from sequencer)
	logic                  a_we, b_we;
	logic [AW-1:0]         waddr;
	logic [DATA_WIDTH-1:0] wdata;
	logic [AW-1:0]         a_raddr, b_raddr;
	logic [DATA_WIDTH-1:0] a_rdata, b_rdata;
	logic                  adv;   // pipe advances: output slot free or draining
	imm_pkg::imm_tag_t     tag_s1;

	// Sequencer: config registers, dimension checks, i/j/n loop, store writes.
	imm_seq #(
		.MAX_DIM    (MAX_DIM),
		.DATA_WIDTH (DATA_WIDTH)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.adv       (adv),
		.a_we      (a_we),
		.b_we      (b_we),
		.waddr     (waddr),
		.wdata     (wdata),
		.a_raddr   (a_raddr),
		.b_raddr   (b_raddr),
		.tag_s1    (tag_s1)
	);

	// Matrix A store, entry (r, c) at r*MAX_DIM + c.
	imm_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (DEPTH)
	) u_ram_a (
		.clk   (clk),
		.we    (a_we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (adv),
		.raddr (a_raddr),
		.rdata (a_rdata)
	);

	// Matrix B store, same layout.
	imm_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (DEPTH)
	) u_ram_b (
		.clk   (clk),
		.we    (b_we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (adv),
		.raddr (b_raddr),
		.rdata (b_rdata)
	);

	// Multiply, accumulate over n, and the output register.
	imm_mac #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.tag_s1    (tag_s1),
		.a_rdata   (a_rdata),
		.b_rdata   (b_rdata),
		.adv       (adv),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

// ===== verif/integer_matrix_multiply_core_tb.sv =====
`default_nettype none

// Checks the integer matrix multiply core against a predictor that keeps its own
// copy of both element stores and the four dimension registers.
//
// Flow:
//   - element writes and multiply commands go in over the in channel, one per transfer
//   - each accepted multiply pushes its expected products (or one error result)
//     onto product_queue
//   - every result transfer on the out channel is compared against the oldest
//     entry in product_queue, field by field
//   - dimension registers are only reprogrammed once product_queue has drained
//     and the pipe has had a few cycles to go quiet
//
// The stores come up undefined, so no multiply reads an entry that was never written.
// load_missing fills in any entry that a multiply would touch before the
// multiply goes in.

module integer_matrix_multiply_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_DIM        = imm_pkg::MAX_DIM_DEF;
	localparam int STORE_DEPTH    = MAX_DIM * MAX_DIM;
	localparam logic [1:0] ACT_UNUSED = 2'd3;  // no meaning in the block, must be dropped
	localparam int SETTLE_CYCLES  = 8;         // settle wait after the result queue drains
	localparam int HOLD_CYCLES    = 300;       // long receiver hold-off
	localparam int CYCLE_LIMIT    = 500000;
	localparam int REPORT_LIMIT   = 10;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [1:0]         cfg_index;
	logic [3:0]         cfg_data;
	logic               in_valid;
	logic               in_stall;
	imm_pkg::in_item_t  in_data;
	logic               out_valid;
	logic               out_stall;
	imm_pkg::out_item_t out_data;

	integer_matrix_multiply_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	// ------------------------------------------------------------------
	// Predictor state
	// ------------------------------------------------------------------
	logic signed [15:0] a_store [STORE_DEPTH];
	logic signed [15:0] b_store [STORE_DEPTH];
	bit                 a_loaded [STORE_DEPTH];
	bit                 b_loaded [STORE_DEPTH];
	logic [3:0]         dim_reg [4];
	imm_pkg::out_item_t product_queue [$];

	// Run bookkeeping
	bit idle_on;        // random gaps on both channels
	bit hold_request;   // ask the receiver for one long hold-off
	int transfers_in;
	int work_items;     // writes and multiplies, not the ignored action
	int multiplies;
	int error_results;
	int results_seen;
	int mismatches;
	int cycle_count;

	// Registers above MAX_DIM saturate.
	function automatic int dim_in_use(logic [3:0] d);
		return (d > MAX_DIM) ? MAX_DIM : int'(d);
	endfunction

	// Apply one accepted input transfer to the predictor and queue what it produces.
	function automatic void predict_transfer(imm_pkg::in_item_t it);
		int ar, ac, br, bc, idx, i, j, n;
		logic signed [imm_pkg::ACC_WIDTH-1:0] acc;
		imm_pkg::out_item_t res;
		ar  = dim_in_use(dim_reg[imm_pkg::REG_A_ROWS]);
		ac  = dim_in_use(dim_reg[imm_pkg::REG_A_COLS]);
		br  = dim_in_use(dim_reg[imm_pkg::REG_B_ROWS]);
		bc  = dim_in_use(dim_reg[imm_pkg::REG_B_COLS]);
		idx = int'(it.row_index) * MAX_DIM + int'(it.col_index);
		res = '0;
		case (it.action)
			imm_pkg::ACT_WRITE_A: begin
				a_store[idx]  = it.element_value;
				a_loaded[idx] = 1'b1;
				work_items++;
			end
			imm_pkg::ACT_WRITE_B: begin
				b_store[idx]  = it.element_value;
				b_loaded[idx] = 1'b1;
				work_items++;
			end
			imm_pkg::ACT_MULTIPLY: begin
				work_items++;
				multiplies++;
				if (ar == 0 || ac == 0 || br == 0 || bc == 0) begin
					// empty matrix wins over a mismatch
					res.status = imm_pkg::ST_EMPTY;
					res.last   = 1'b1;
					product_queue.push_back(res);
					error_results++;
				end else if (ac != br) begin
					res.status = imm_pkg::ST_MISMATCH;
					res.last   = 1'b1;
					product_queue.push_back(res);
					error_results++;
				end else begin
					for (i = 0; i < ar; i++) begin
						for (j = 0; j < bc; j++) begin
							acc = '0;
							for (n = 0; n < ac; n++)
								acc = acc + a_store[i*MAX_DIM + n] * b_store[n*MAX_DIM + j];
							res.status        = imm_pkg::ST_OK;
							res.out_row       = 3'(i);
							res.out_col       = 3'(j);
							res.product_value = acc;
							res.last          = (i == ar - 1) && (j == bc - 1);
							product_queue.push_back(res);
						end
					end
				end
			end
			default: ;  // unused action: no state change, no result
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Clock, reset, cycle limit
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results still pending",
				cycle_count, product_queue.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Receiver: out_stall driven at negedge. Random bursts while idle_on,
	// plus one long hold-off on request so the pipe backs up into in_stall.
	// ------------------------------------------------------------------
	initial begin : receiver_stall
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_request = 1'b0;
				out_stall <= 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 19)) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Result checker: sample at rising edge, compare with oldest expectation
	// ------------------------------------------------------------------
	function automatic void flag_mismatch(string what, imm_pkg::out_item_t want,
		imm_pkg::out_item_t got);
		mismatches++;
		if (mismatches <= REPORT_LIMIT)
			$display("[%0t] mismatch on %s: expected st=%0d r=%0d c=%0d v=%0d last=%0b, got st=%0d r=%0d c=%0d v=%0d last=%0b",
				$realtime, what,
				want.status, want.out_row, want.out_col, want.product_value, want.last,
				got.status, got.out_row, got.out_col, got.product_value, got.last);
	endfunction

	always @(posedge clk) begin : check_products
		imm_pkg::out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (product_queue.size() == 0) begin
				want = '0;
				flag_mismatch("result with nothing pending", want, out_data);
			end else begin
				want = product_queue.pop_front();
				if (out_data.status !== want.status)
					flag_mismatch("status", want, out_data);
				if (out_data.out_row !== want.out_row)
					flag_mismatch("out_row", want, out_data);
				if (out_data.out_col !== want.out_col)
					flag_mismatch("out_col", want, out_data);
				if (out_data.product_value !== want.product_value)
					flag_mismatch("product_value", want, out_data);
				if (out_data.last !== want.last)
					flag_mismatch("last", want, out_data);
			end
		end
	end

	// ------------------------------------------------------------------
	// Sender side. All tasks enter and leave on a falling edge.
	// ------------------------------------------------------------------

	// One input transfer. in_valid stays high on return so back-to-back
	// items go out without a bubble; whoever stops sending lowers it.
	task automatic send_item(imm_pkg::in_item_t it);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		in_data  <= it;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		transfers_in++;
		predict_transfer(it);
		@(negedge clk);
	endtask

	task automatic write_element(logic [1:0] act, int r, int c, logic signed [15:0] v);
		imm_pkg::in_item_t it;
		it.action        = act;
		it.row_index     = 3'(r);
		it.col_index     = 3'(c);
		it.element_value = v;
		send_item(it);
	endtask

	// Mostly random, with the corners of the 16-bit range mixed in.
	function automatic logic signed [15:0] rand_element();
		case ($urandom_range(0, 7))
			0:       return 16'sh8000;
			1:       return 16'sh7fff;
			2:       return '0;
			3:       return '1;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_unused_item();
		imm_pkg::in_item_t it;
		it = {ACT_UNUSED, 3'($urandom), 3'($urandom), 16'($urandom)};
		send_item(it);
	endtask

	// Fill every entry the current dimensions will read that has never been written.
	task automatic load_missing();
		int ar, ac, br, bc, r, c;
		ar = dim_in_use(dim_reg[imm_pkg::REG_A_ROWS]);
		ac = dim_in_use(dim_reg[imm_pkg::REG_A_COLS]);
		br = dim_in_use(dim_reg[imm_pkg::REG_B_ROWS]);
		bc = dim_in_use(dim_reg[imm_pkg::REG_B_COLS]);
		for (r = 0; r < ar; r++)
			for (c = 0; c < ac; c++)
				if (!a_loaded[r*MAX_DIM + c])
					write_element(imm_pkg::ACT_WRITE_A, r, c, rand_element());
		for (r = 0; r < br; r++)
			for (c = 0; c < bc; c++)
				if (!b_loaded[r*MAX_DIM + c])
					write_element(imm_pkg::ACT_WRITE_B, r, c, rand_element());
	endtask

	// Multiply command. Row, column and value fields carry junk, the block ignores them.
	task automatic run_multiply();
		imm_pkg::in_item_t it;
		int ac, br;
		ac = dim_in_use(dim_reg[imm_pkg::REG_A_COLS]);
		br = dim_in_use(dim_reg[imm_pkg::REG_B_ROWS]);
		if (ac == br)
			load_missing();
		it.action        = imm_pkg::ACT_MULTIPLY;
		it.row_index     = 3'($urandom);
		it.col_index     = 3'($urandom);
		it.element_value = 16'($urandom);
		send_item(it);
	endtask

	// Stop sending and let every pending result come out, then give any
	// write still in flight time to land.
	task automatic wait_for_drain();
		in_valid <= 1'b0;
		while (product_queue.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// All four dimension registers, written back to back while the block is idle.
	task automatic program_dims(logic [3:0] ar, logic [3:0] ac, logic [3:0] br,
		logic [3:0] bc);
		logic [1:0] reg_order [4];
		logic [3:0] vals [4];
		int k;
		reg_order = '{imm_pkg::REG_A_ROWS, imm_pkg::REG_A_COLS, imm_pkg::REG_B_ROWS,
			imm_pkg::REG_B_COLS};
		vals      = '{ar, ac, br, bc};
		wait_for_drain();
		for (k = 0; k < 4; k++) begin
			cfg_we    <= 1'b1;
			cfg_index <= reg_order[k];
			cfg_data  <= vals[k];
			@(negedge clk);
			dim_reg[reg_order[k]] = vals[k];
		end
		cfg_we <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Dimensions come out of reset at 1x1 by 1x1. Also checks that the
	// unused action leaves the store alone.
	task automatic test_reset_dimensions();
		write_element(imm_pkg::ACT_WRITE_A, 0, 0, 16'sh8000);
		write_element(imm_pkg::ACT_WRITE_B, 0, 0, 16'sh8000);
		run_multiply();               // -32768 * -32768
		send_unused_item();
		send_unused_item();
		run_multiply();               // same answer, store untouched
		write_element(imm_pkg::ACT_WRITE_A, 0, 0, 16'sh7fff);
		run_multiply();               // max * min
	endtask

	// Empty matrix for each zero register, and the empty check wins over an
	// inner mismatch. Then mismatches, including one that survives saturation.
	task automatic test_error_status();
		program_dims(4'd0, 4'd2, 4'd5, 4'd3);
		run_multiply();
		program_dims(4'd3, 4'd0, 4'd5, 4'd3);
		run_multiply();
		program_dims(4'd3, 4'd2, 4'd0, 4'd3);
		run_multiply();
		program_dims(4'd3, 4'd2, 4'd5, 4'd0);
		run_multiply();
		program_dims(4'd2, 4'd3, 4'd4, 4'd2);
		run_multiply();
		program_dims(4'd2, 4'd12, 4'd7, 4'd2);   // 12 saturates to 8, still != 7
		run_multiply();
	endtask

	// Largest sizes through saturated registers (15 and 9 both read as 8).
	// An 8x1 by 1x8 gives the full 64 results; a 1x8 by 8x1 with every term
	// at the most negative value pushes the sum to 2^33.
	task automatic test_largest_matrices();
		int k;
		program_dims(4'd15, 4'd1, 4'd1, 4'd9);
		for (k = 0; k < MAX_DIM; k++) begin
			write_element(imm_pkg::ACT_WRITE_A, k, 0, 16'sh8000);
			write_element(imm_pkg::ACT_WRITE_B, 0, k, 16'sh8000);
		end
		run_multiply();
		program_dims(4'd1, 4'd15, 4'd9, 4'd1);
		for (k = 1; k < MAX_DIM; k++) begin
			write_element(imm_pkg::ACT_WRITE_A, 0, k, 16'sh8000);
			write_element(imm_pkg::ACT_WRITE_B, k, 0, 16'sh8000);
		end
		run_multiply();
		// Row 0 of A at the positive limit: the sum goes hugely negative
		for (k = 0; k < MAX_DIM; k++)
			write_element(imm_pkg::ACT_WRITE_A, 0, k, 16'sh7fff);
		run_multiply();
	endtask

	// Receiver holds off for a long stretch while the sender keeps offering:
	// the pipe fills and in_stall has to hold the next items back.
	task automatic test_output_holdoff();
		int k;
		program_dims(4'd4, 4'd4, 4'd4, 4'd4);
		load_missing();
		hold_request = 1'b1;
		run_multiply();
		for (k = 0; k < 6; k++)
			write_element($urandom_range(0, 1) ? imm_pkg::ACT_WRITE_B : imm_pkg::ACT_WRITE_A,
				$urandom_range(0, 3), $urandom_range(0, 3), rand_element());
		run_multiply();
		wait_for_drain();
		while (hold_request) @(negedge clk);
	endtask

	// One random phase: pick dimensions (mostly small well-formed products,
	// sometimes empty, mismatched or with a saturated inner dimension),
	// scatter writes, multiply.
	task automatic random_phase();
		int ar, ac, br, bc, k, n_writes, rmax, cmax;
		logic [1:0] act;
		ar = $urandom_range(1, 4);
		ac = $urandom_range(1, 4);
		bc = $urandom_range(1, 4);
		br = ac;
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 3))
					0:       ar = 0;
					1:       ac = 0;
					2:       br = 0;
					default: bc = 0;
				endcase
			end
			1: br = (ac % 4) + 1;   // inner dimensions differ
			2: begin                // full inner dimension, often above the saturation point
				ar = $urandom_range(1, 3);
				ac = $urandom_range(8, 15);
				br = $urandom_range(8, 15);
				bc = $urandom_range(1, 3);
			end
			default: ;
		endcase
		program_dims(4'(ar), 4'(ac), 4'(br), 4'(bc));

		n_writes = $urandom_range(0, 10);
		for (k = 0; k < n_writes; k++) begin
			if ($urandom_range(0, 9) == 0) begin
				send_unused_item();
			end else begin
				act  = $urandom_range(0, 1) ? imm_pkg::ACT_WRITE_B : imm_pkg::ACT_WRITE_A;
				rmax = dim_in_use(4'((act == imm_pkg::ACT_WRITE_A) ? ar : br));
				cmax = dim_in_use(4'((act == imm_pkg::ACT_WRITE_A) ? ac : bc));
				// now and then write outside the region in use
				if (rmax == 0 || $urandom_range(0, 4) == 0)
					rmax = MAX_DIM;
				if (cmax == 0 || $urandom_range(0, 4) == 0)
					cmax = MAX_DIM;
				write_element(act, $urandom_range(0, rmax - 1), $urandom_range(0, cmax - 1),
					rand_element());
			end
		end
		run_multiply();
		if ($urandom_range(0, 3) == 0)
			run_multiply();         // back-to-back multiplies
	endtask

	task automatic test_random_traffic(int target);
		int start;
		start = work_items;
		while (work_items < start + target)
			random_phase();
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin : main_sequence
		int k;
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = imm_pkg::REG_A_ROWS;
		cfg_data     = '0;
		in_valid     = 1'b0;
		in_data      = '0;
		idle_on      = 1'b1;
		hold_request = 1'b0;
		for (k = 0; k < 4; k++)
			dim_reg[k] = 4'd1;
		for (k = 0; k < STORE_DEPTH; k++) begin
			a_loaded[k] = 1'b0;
			b_loaded[k] = 1'b0;
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_dimensions();
		test_error_status();
		test_largest_matrices();
		test_output_holdoff();
		test_random_traffic(30);

		// last stretch at full rate on both sides
		wait_for_drain();
		idle_on = 1'b0;
		test_random_traffic(12);

		wait_for_drain();

		$display("Run covered %0d input transfers (%0d multiplies, %0d giving an error status)",
			transfers_in, multiplies, error_results);
		$display("and %0d checked results, %0d mismatches, %0d cycles",
			results_seen, mismatches, cycle_count);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

`default_nettype wire

// ===== files.f =====
hdl/imm_pkg.sv
hdl/imm_ram.sv
hdl/imm_seq.sv
hdl/imm_mac.sv
hdl/integer_matrix_multiply_core.sv
verif/integer_matrix_multiply_core_tb.sv
